[hdl/ahm_pkg.sv]
// Shared types, codes, reset values and helpers of the alarm hold-off manager.
package ahm_pkg;

	localparam int NUM_ALARMS_DEF = 16;
	localparam int AGE_BITS_DEF   = 16;

	localparam int MASK_W     = 16;
	localparam int STEP_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int FLAG_W     = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EVENT_ONLY_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_AGE         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AGE_STEP        = 2'd3;

	localparam logic [MASK_W-1:0] ENABLE_RST     = 16'd0;
	localparam logic [MASK_W-1:0] EVENT_ONLY_RST = 16'd584;
	localparam logic [15:0]       MIN_AGE_RST    = 16'd0;
	localparam logic [STEP_W-1:0] AGE_STEP_RST   = 8'd1;

	localparam logic OP_SET  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		PH_UNSET   = 2'd0,
		PH_SET     = 2'd1,
		PH_CLEARED = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		NT_NONE   = 2'd0,
		NT_RAISED = 2'd1,
		NT_UNSET  = 2'd2,
		NT_EVENT  = 2'd3
	} notify_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SET,
		ST_WALK
	} ctl_state_t;

	typedef struct packed {
		logic   cond;
		logic   pending;
		phase_t phase;
	} flags_t;

	// Mask bits exist for the first sixteen alarms only.
	function automatic logic mask_bit(input logic [MASK_W-1:0] mask, input logic [7:0] idx);
		logic res;
		res = 1'b0;
		if (idx < 8'd16) begin
			res = mask[idx[3:0]];
		end
		return res;
	endfunction

endpackage

[hdl/alarm_holdoff_manager.sv]
// Top level of the alarm hold-off manager.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  op, alarm_index, condition
//   result    out        out_valid/out_stall  alarm_id, alarm_status, notify, last
//   config    in         cfg_we               cfg_index, cfg_data
//
// A set-condition beat reads memory in the idle state, writes back in the set state.
// An update tick walks one alarm per cycle while the result channel does not stall,
// using the single read and single write port of the state memory.
// A result-channel stall while a result waits holds the walk at a reported alarm.
// Reset clears the configuration to its defaults and marks every memory entry unwritten,
// so all alarms read as unset with zero age; no clearing pass is needed.
module alarm_holdoff_manager #(
	parameter int NUM_ALARMS = ahm_pkg::NUM_ALARMS_DEF,
	parameter int AGE_BITS   = ahm_pkg::AGE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [3:0]                     alarm_index,
	input  logic                           condition,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [3:0]                     alarm_id,
	output logic [1:0]                     alarm_status,
	output logic [1:0]                     notify,
	output logic                           last,
	input  logic                           cfg_we,
	input  logic [ahm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ahm_pkg::CFG_DATA_W-1:0] cfg_data
);

	import ahm_pkg::*;

	localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
	localparam int ENT_W = AGE_BITS + FLAG_W;

	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	logic [ENT_W-1:0] mem_wdata, mem_rdata;

	ahm_ctrl #(
		.NUM_ALARMS(NUM_ALARMS),
		.AGE_BITS  (AGE_BITS),
		.IDX_W     (IDX_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.alarm_index (alarm_index),
		.condition   (condition),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.alarm_id    (alarm_id),
		.alarm_status(alarm_status),
		.notify      (notify),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	ahm_state_mem #(
		.DEPTH(NUM_ALARMS),
		.WIDTH(ENT_W),
		.IDX_W(IDX_W)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

[hdl/ahm_state_mem.sv]
// Alarm state memory: one write and one registered read port, entries read as zero until written.
module ahm_state_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 20,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic [WIDTH-1:0] rd_data_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_valid_q <= written_q[raddr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_data_q : '0;

endmodule

[hdl/ahm_ctrl.sv]
// Sequencer of the alarm hold-off manager: configuration, read-modify-write and result register.
module ahm_ctrl #(
	parameter int NUM_ALARMS = 16,
	parameter int AGE_BITS   = 16,
	parameter int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [3:0]                    alarm_index,
	input  logic                          condition,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [3:0]                    alarm_id,
	output logic [1:0]                    alarm_status,
	output logic [1:0]                    notify,
	output logic                          last,
	input  logic                          cfg_we,
	input  logic [ahm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ahm_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          mem_we,
	output logic [IDX_W-1:0]              mem_waddr,
	output logic [AGE_BITS+ahm_pkg::FLAG_W-1:0] mem_wdata,
	output logic                          mem_re,
	output logic [IDX_W-1:0]              mem_raddr,
	input  logic [AGE_BITS+ahm_pkg::FLAG_W-1:0] mem_rdata
);

	import ahm_pkg::*;

	localparam int REPORTED = (NUM_ALARMS < 16) ? NUM_ALARMS : 16;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ALARMS - 1);
	localparam logic [IDX_W-1:0] LAST_REP = IDX_W'(REPORTED - 1);

	ctl_state_t          state_q, state_d;
	logic [IDX_W-1:0]    idx_q;
	logic                cond_q;
	logic                in_range_q;
	logic [MASK_W-1:0]   enable_q;
	logic [MASK_W-1:0]   event_q;
	logic [15:0]         min_age_q;
	logic [STEP_W-1:0]   age_step_q;

	logic                out_valid_q;
	logic [3:0]          out_id_q;
	logic [1:0]          out_status_q;
	logic [1:0]          out_notify_q;
	logic                out_last_q;

	flags_t              fl_rd, fl_tk, fl_st;
	logic [AGE_BITS-1:0] age_rd, age_tk, age_next;
	logic [AGE_BITS:0]   age_sum;
	notify_t             note_tk;
	logic                en_bit, ev_bit, reported, age_old, set_do, advance, out_load;

	assign {fl_rd, age_rd} = mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= ENABLE_RST;
			event_q    <= EVENT_ONLY_RST;
			min_age_q  <= MIN_AGE_RST;
			age_step_q <= AGE_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE_MASK:     enable_q   <= cfg_data;
				CFG_EVENT_ONLY_MASK: event_q    <= cfg_data;
				CFG_MIN_AGE:         min_age_q  <= cfg_data;
				CFG_AGE_STEP:        age_step_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign en_bit   = mask_bit(enable_q, 8'(idx_q));
	assign ev_bit   = mask_bit(event_q, 8'(idx_q));
	assign reported = 32'(idx_q) < REPORTED;
	assign age_sum  = {1'b0, age_rd} + (AGE_BITS + 1)'(age_step_q);
	assign age_next = age_sum[AGE_BITS] ? '1 : age_sum[AGE_BITS-1:0];
	assign age_old  = 32'(age_rd) >= 32'(min_age_q);
	assign advance  = !reported || !out_valid_q || !out_stall;

	always_comb begin
		fl_tk   = fl_rd;
		age_tk  = age_rd;
		note_tk = NT_NONE;
		if (en_bit) begin
			if (ev_bit) begin
				if (fl_rd.cond) begin
					note_tk     = NT_EVENT;
					fl_tk.cond  = 1'b0;
				end
			end else begin
				if (!fl_rd.cond) begin
					if (fl_rd.phase == PH_CLEARED && age_old) begin
						fl_tk.phase = PH_UNSET;
						note_tk     = NT_UNSET;
					end else if (fl_rd.phase == PH_SET) begin
						fl_tk.phase = PH_CLEARED;
					end
				end else if (age_rd == '0) begin
					fl_tk.phase = PH_SET;
					if (fl_rd.phase == PH_UNSET) begin
						note_tk = NT_RAISED;
					end
				end
				age_tk = age_next;
			end
			fl_tk.pending = 1'b0;
		end
	end

	// A clearing is refused while the previous change is still unhandled.
	always_comb begin
		fl_st         = fl_rd;
		fl_st.cond    = cond_q;
		fl_st.pending = 1'b1;
		set_do = in_range_q && en_bit && (cond_q != fl_rd.cond) && !(!cond_q && fl_rd.pending);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (op == OP_TICK) ? ST_WALK : ST_SET;
				end
			end
			ST_SET: begin
				state_d = ST_IDLE;
			end
			ST_WALK: begin
				if (advance && idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = {fl_tk, age_tk};
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				mem_re    = in_valid;
				mem_raddr = (op == OP_TICK) ? '0 : IDX_W'(alarm_index);
			end
			ST_SET: begin
				mem_we    = set_do;
				mem_wdata = {fl_st, {AGE_BITS{1'b0}}};
			end
			ST_WALK: begin
				mem_we    = advance;
				mem_re    = advance && (idx_q != LAST_IDX);
				mem_raddr = idx_q + 1'b1;
				out_load  = advance && reported;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid) begin
				idx_q <= (op == OP_TICK) ? '0 : IDX_W'(alarm_index);
			end else if (state_q == ST_WALK && advance) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cond_q     <= condition;
			in_range_q <= 32'(alarm_index) < NUM_ALARMS;
		end
		if (out_load) begin
			out_id_q     <= 4'(idx_q);
			out_status_q <= fl_tk.phase;
			out_notify_q <= note_tk;
			out_last_q   <= idx_q == LAST_REP;
		end
	end

	assign out_valid    = out_valid_q;
	assign alarm_id     = out_id_q;
	assign alarm_status = out_status_q;
	assign notify       = out_notify_q;
	assign last         = out_last_q;

`ifndef SYNTH
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_re && mem_we) |-> (mem_raddr != mem_waddr))
		else $error("read and write address the same entry in one cycle");

	a_walk_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && advance && idx_q != LAST_IDX)
		|=> (state_q == ST_WALK && idx_q == $past(idx_q) + 1'b1))
		else $error("walk did not move on to the next alarm");

	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && advance && idx_q == LAST_IDX) |=> (state_q == ST_IDLE))
		else $error("walk did not finish after the highest alarm");

	a_out_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_WALK))
		else $error("result produced outside an update walk");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("state memory written while idle");
`endif

endmodule
